// ----- rtl/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants and types for the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 7;
   localparam int LEN_W    = 7;
   localparam int DATA_W   = 32;
   localparam int REQ_W    = 3;
   // compare width that holds any position, any count and count plus one
   localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [REQ_W-1:0] REQ_GET    = 3'd0;
   localparam logic [REQ_W-1:0] REQ_LOCATE = 3'd1;
   localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
   localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

   localparam logic [1:0] CELL_HOLD = 2'd0;
   localparam logic [1:0] CELL_LOAD = 2'd1;
   localparam logic [1:0] CELL_UP   = 2'd2;
   localparam logic [1:0] CELL_DOWN = 2'd3;

   typedef struct packed {
      logic [1:0]               mode;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

// ----- rtl/sle_req_if.sv -----
// ----------------------------------------------------------------------------
// sle_req_if
// Request channel: operation, list position and value.
// ----------------------------------------------------------------------------
interface sle_req_if import sle_pkg::*; ;
   logic                     valid;
   logic                     ready;
   logic [REQ_W-1:0]         req_type;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, req_type, position, value, input ready);
   modport sink   (input valid, req_type, position, value, output ready);
endinterface

// ----- rtl/sle_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sle_rsp_if
// Response channel: status, element, match position and list length.
// ----------------------------------------------------------------------------
interface sle_rsp_if import sle_pkg::*; ;
   logic                     valid;
   logic                     ready;
   logic                     ok;
   logic signed [DATA_W-1:0] element;
   logic [LEN_W-1:0]         found_position;
   logic [LEN_W-1:0]         list_length;
   logic                     is_empty;

   modport source (output valid, ok, element, found_position, list_length, is_empty,
                   input ready);
   modport sink   (input valid, ok, element, found_position, list_length, is_empty,
                   output ready);
endinterface

// ----- rtl/sequential_list_engine.sv -----
// An accepted request is compared, then selected and executed; its response is registered.
// Requests do not overlap: a new one is accepted only in idle, after the last has executed.
// A stalled response holds the engine in its execute step until taken.
// Reset (synchronous, active high) empties the list and drops any pending item;
// element cells are not cleared, only positions below the length are ever read.
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list in a row of shifting cells: get, locate, insert, delete, clear.
// ----------------------------------------------------------------------------
module sequential_list_engine import sle_pkg::*; (
   input  logic clock,
   input  logic reset,
   sle_req_if.sink   req_chan,
   sle_rsp_if.source rsp_chan
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CMP  = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [REQ_W-1:0]         op_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CAPACITY-1:0]      first_ff;
   logic [CAPACITY-1:0]      hit;

   logic                     rsp_valid_ff;
   logic                     ok_ff;
   logic signed [DATA_W-1:0] element_ff;
   logic [LEN_W-1:0]         found_ff;
   logic [LEN_W-1:0]         length_ff;
   logic                     empty_ff;

   logic signed [DATA_W-1:0] cell_data [CAPACITY];
   logic [CAPACITY-1:0]      cell_match;
   cell_cmd_type             cell_cmd [CAPACITY];

   logic [CMP_W-1:0] pos_w, cnt_w;
   logic             pos_in_list, ins_ok, go, exec_ok;
   logic signed [DATA_W-1:0] sel_data;
   logic [CNT_W-1:0] sel_index;

   assign pos_w       = CMP_W'(pos_ff);
   assign cnt_w       = CMP_W'(count_ff);
   assign pos_in_list = (pos_w != '0) && (pos_w <= cnt_w);
   assign ins_ok      = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1))
                        && (cnt_w < CMP_W'(CAPACITY));
   assign go          = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      case (op_ff)
         REQ_GET, REQ_DELETE:  exec_ok = pos_in_list;
         REQ_INSERT:           exec_ok = ins_ok;
         REQ_LOCATE, REQ_CLEAR: exec_ok = 1'b1;
         default:              exec_ok = 1'b0;
      endcase
   end

   // row of cells, each with its own shift decision
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         localparam logic [CMP_W-1:0] SLOT = CMP_W'(gi + 1);
         logic signed [DATA_W-1:0] left_d, right_d;

         if (gi == 0) begin : g_first
            assign left_d = '0;
         end else begin : g_mid_l
            assign left_d = cell_data[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[gi];
         end else begin : g_mid_r
            assign right_d = cell_data[gi+1];
         end

         always_comb begin
            cell_cmd[gi].value = value_ff;
            cell_cmd[gi].mode  = CELL_HOLD;
            if (go && exec_ok) begin
               if (op_ff == REQ_INSERT) begin
                  if (SLOT == pos_w) begin
                     cell_cmd[gi].mode = CELL_LOAD;
                  end else if (SLOT > pos_w) begin
                     cell_cmd[gi].mode = CELL_UP;
                  end
               end else if (op_ff == REQ_DELETE && SLOT >= pos_w) begin
                  cell_cmd[gi].mode = CELL_DOWN;
               end
            end
         end

         always_comb begin
            case (op_ff)
               REQ_LOCATE:          hit[gi] = cell_match[gi] && (SLOT <= cnt_w);
               REQ_GET, REQ_DELETE: hit[gi] = (SLOT == pos_w);
               default:             hit[gi] = 1'b0;
            endcase
         end

         sle_cell u_cell (
            .clock      (clock),
            .cmd        (cell_cmd[gi]),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[gi]),
            .match      (cell_match[gi])
         );
      end
   endgenerate

   // one-hot selection: independent per cell, merged by OR
   always_comb begin
      sel_data  = '0;
      sel_index = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_data  = sel_data | (first_ff[i] ? cell_data[i] : '0);
         sel_index = sel_index | (first_ff[i] ? CNT_W'(i + 1) : '0);
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: if (req_chan.valid) state_in = ST_CMP;
         ST_CMP:  state_in = ST_EXEC;
         ST_EXEC: begin
            if (go) begin
               state_in = ST_IDLE;
               if (exec_ok) begin
                  case (op_ff)
                     REQ_INSERT: count_in = count_ff + CNT_W'(1);
                     REQ_DELETE: count_in = count_ff - CNT_W'(1);
                     REQ_CLEAR:  count_in = '0;
                     default:    count_in = count_ff;
                  endcase
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         op_ff    <= req_chan.req_type;
         pos_ff   <= req_chan.position;
         value_ff <= req_chan.value;
      end
      if (state_ff == ST_CMP) begin
         // keep only the lowest match
         first_ff <= hit & (~hit + CAPACITY'(1));
      end
      if (go) begin
         ok_ff      <= exec_ok;
         element_ff <= (exec_ok && (op_ff == REQ_GET || op_ff == REQ_DELETE)) ? sel_data : '0;
         found_ff   <= (op_ff == REQ_LOCATE) ? LEN_W'(sel_index) : '0;
         length_ff  <= LEN_W'(count_in);
         empty_ff   <= (count_in == '0);
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.ok             = ok_ff;
   assign rsp_chan.element        = element_ff;
   assign rsp_chan.found_position = found_ff;
   assign rsp_chan.list_length    = length_ff;
   assign rsp_chan.is_empty       = empty_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("list length above capacity");

   a_first_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> $onehot0(first_ff))
      else $error("more than one cell selected");

   a_stall_holds_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> $stable(count_ff))
      else $error("list changed while response stalled");

   a_idle_after_exec: assert property (@(posedge clock) disable iff (reset)
      go |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("execute step did not post a response");
`endif

endmodule

// ----- rtl/sle_cell.sv -----
// ----------------------------------------------------------------------------
// sle_cell
// One list slot: holds an element, loads, shifts from a neighbor or holds.
// ----------------------------------------------------------------------------
module sle_cell import sle_pkg::*; (
   input  logic                     clock,
   input  cell_cmd_type             cmd,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   output logic signed [DATA_W-1:0] data,
   output logic                     match
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      case (cmd.mode)
         CELL_LOAD: data_in = cmd.value;
         CELL_UP:   data_in = left_data;
         CELL_DOWN: data_in = right_data;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign match = (data_ff == cmd.value);

endmodule

// ----- test/sequential_list_engine_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine_test
// Self-checking bench for the list engine. A shadow list in the bench
// predicts every response: status, element, match position, length and the
// empty flag. The run starts with short directed checks on an empty list, on
// each operation and on a full list. It then runs random traffic in phases
// that grow, churn and shrink the list, with random stalls on both channels.
// ----------------------------------------------------------------------------
module sequential_list_engine_test import sle_pkg::*; ;

   localparam logic [REQ_W-1:0] REQ_UNKNOWN_FIRST = 3'd5;
   localparam logic [REQ_W-1:0] REQ_UNKNOWN_LAST  = 3'd7;
   localparam int IDLE_PERCENT    = 35;
   localparam int RANDOM_ITEMS    = 2000;
   localparam int MAX_REPORTS     = 40;
   localparam int DRAIN_CYCLES    = 12;

   typedef struct {
      logic                     ok;
      logic signed [DATA_W-1:0] element;
      logic [LEN_W-1:0]         found_position;
      logic [LEN_W-1:0]         list_length;
      logic                     is_empty;
   } list_result_type;

   logic clock;
   logic reset;

   sle_req_if req_if ();
   sle_rsp_if rsp_if ();

   sequential_list_engine i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // shadow list; cells at or above shadow_count are never read
   logic signed [DATA_W-1:0] shadow_cells [CAPACITY];
   int                       shadow_count;
   list_result_type          pending_results [$];

   bit steady_flow;
   int error_count;
   int items_sent;
   int results_checked;
   int full_refusals;
   int locate_hits;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic list_result_type apply_list_request(
      input logic [REQ_W-1:0]         op,
      input logic [POS_W-1:0]         pos,
      input logic signed [DATA_W-1:0] val
   );
      list_result_type res;
      int              p;
      int              j;
      res = '{ok: 1'b0, element: '0, found_position: '0, list_length: '0, is_empty: 1'b0};
      p = int'(pos);
      case (op)
         REQ_GET: begin
            if (p >= 1 && p <= shadow_count) begin
               res.element = shadow_cells[p-1];
               res.ok      = 1'b1;
            end
         end
         REQ_LOCATE: begin
            res.ok = 1'b1;
            for (j = 0; j < shadow_count; j++) begin
               if (shadow_cells[j] == val) begin
                  res.found_position = LEN_W'(j + 1);
                  locate_hits++;
                  break;
               end
            end
         end
         REQ_INSERT: begin
            if (shadow_count == CAPACITY) begin
               full_refusals++;
            end else if (p >= 1 && p <= shadow_count + 1) begin
               for (j = shadow_count; j > p - 1; j--) begin
                  shadow_cells[j] = shadow_cells[j-1];
               end
               shadow_cells[p-1] = val;
               shadow_count++;
               res.ok = 1'b1;
            end
         end
         REQ_DELETE: begin
            if (p >= 1 && p <= shadow_count) begin
               res.element = shadow_cells[p-1];
               for (j = p - 1; j + 1 < shadow_count; j++) begin
                  shadow_cells[j] = shadow_cells[j+1];
               end
               shadow_count--;
               res.ok = 1'b1;
            end
         end
         REQ_CLEAR: begin
            shadow_count = 0;
            res.ok       = 1'b1;
         end
         default: begin
         end
      endcase
      res.list_length = LEN_W'(shadow_count);
      res.is_empty    = (shadow_count == 0);
      return res;
   endfunction

   task automatic send_request(
      input logic [REQ_W-1:0]         op,
      input logic [POS_W-1:0]         pos,
      input logic signed [DATA_W-1:0] val
   );
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= op;
      req_if.position <= pos;
      req_if.value    <= val;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_results.push_back(apply_list_request(op, pos, val));
      items_sent++;
   endtask

   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(9))
         0:       return {1'b1, {(DATA_W-1){1'b0}}};
         1:       return {1'b0, {(DATA_W-1){1'b1}}};
         2, 3, 4: return $signed($urandom_range(6)) - 3;
         default: return $urandom;
      endcase
   endfunction

   // mostly in range, some at the edges, a few anywhere
   function automatic logic [POS_W-1:0] random_position(input int limit);
      int r;
      r = $urandom_range(99);
      if (r < 85 && limit >= 1) return POS_W'($urandom_range(limit, 1));
      if (r < 95) return ($urandom_range(1) != 0 || limit + 1 > 127) ? '0 : POS_W'(limit + 1);
      return POS_W'($urandom_range(127));
   endfunction

   task automatic note_mismatch(input string field, input longint exp_val,
                                input longint act_val);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, field, exp_val, act_val);
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      list_result_type exp_res;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            note_mismatch("unexpected result, length", -1, rsp_if.list_length);
         end else begin
            exp_res = pending_results.pop_front();
            results_checked++;
            if (rsp_if.ok !== exp_res.ok)
               note_mismatch("ok", exp_res.ok, rsp_if.ok);
            if (rsp_if.element !== exp_res.element)
               note_mismatch("element", exp_res.element, rsp_if.element);
            if (rsp_if.found_position !== exp_res.found_position)
               note_mismatch("found_position", exp_res.found_position,
                             rsp_if.found_position);
            if (rsp_if.list_length !== exp_res.list_length)
               note_mismatch("list_length", exp_res.list_length, rsp_if.list_length);
            if (rsp_if.is_empty !== exp_res.is_empty)
               note_mismatch("is_empty", exp_res.is_empty, rsp_if.is_empty);
         end
      end
   end

   task automatic test_empty_list();
      send_request(REQ_CLEAR, 0, 0);
      send_request(REQ_GET, 1, 0);
      send_request(REQ_GET, 0, 0);
      send_request(REQ_DELETE, 1, 0);
      send_request(REQ_LOCATE, 0, 0);
      send_request(REQ_INSERT, 0, 7);
      send_request(REQ_INSERT, 2, 7);
   endtask

   task automatic test_each_operation();
      send_request(REQ_INSERT, 1, {1'b1, {(DATA_W-1){1'b0}}});
      send_request(REQ_INSERT, 1, {1'b0, {(DATA_W-1){1'b1}}});
      send_request(REQ_INSERT, 3, 0);
      send_request(REQ_INSERT, 2, -1);
      send_request(REQ_GET, 1, 0);
      send_request(REQ_GET, 2, 0);
      send_request(REQ_GET, 4, 0);
      send_request(REQ_GET, 5, 0);
      send_request(REQ_LOCATE, 127, {1'b1, {(DATA_W-1){1'b0}}});
      send_request(REQ_LOCATE, 0, 12345);
      // duplicate at the tail: locate must report the first match
      send_request(REQ_INSERT, 5, -1);
      send_request(REQ_LOCATE, 0, -1);
      send_request(REQ_DELETE, 2, 0);
      send_request(REQ_LOCATE, 0, -1);
      send_request(REQ_DELETE, 127, 0);
      send_request(REQ_INSERT, 127, 9);
      send_request(REQ_UNKNOWN_FIRST, 1, 0);
      send_request(REQ_W'(REQ_UNKNOWN_FIRST + 1), 2, -1);
      send_request(REQ_UNKNOWN_LAST, 127, 0);
      send_request(REQ_CLEAR, 0, 0);
      send_request(REQ_GET, 1, 0);
   endtask

   // runs without stalls on either side
   task automatic test_full_list();
      steady_flow = 1'b1;
      send_request(REQ_CLEAR, 0, 0);
      repeat (CAPACITY) send_request(REQ_INSERT,
                                     POS_W'($urandom_range(shadow_count + 1, 1)),
                                     random_value());
      send_request(REQ_INSERT, 1, 42);
      send_request(REQ_INSERT, POS_W'(CAPACITY + 1), 42);
      send_request(REQ_GET, POS_W'(CAPACITY), 0);
      send_request(REQ_GET, POS_W'(CAPACITY + 1), 0);
      send_request(REQ_LOCATE, 0, shadow_cells[CAPACITY-1]);
      send_request(REQ_DELETE, POS_W'(CAPACITY), 0);
      send_request(REQ_INSERT, POS_W'(CAPACITY), -5);
      send_request(REQ_DELETE, 1, 0);
      steady_flow = 1'b0;
   endtask

   task automatic test_random_traffic();
      int                       phase;
      int                       ins_w;
      int                       del_w;
      int                       clr_w;
      int                       r;
      logic signed [DATA_W-1:0] val;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         phase       = (i / 200) % 4;
         steady_flow = (i >= 1000 && i < 1150);
         ins_w = (phase == 0) ? 60 : (phase == 2) ? 15 : 30;
         del_w = (phase == 2) ? 50 : (phase == 0) ? 10 : 25;
         clr_w = (phase == 3) ? 4 : 1;
         r = $urandom_range(99);
         if (r < ins_w) begin
            send_request(REQ_INSERT, random_position(shadow_count + 1), random_value());
         end else if (r < ins_w + del_w) begin
            send_request(REQ_DELETE, random_position(shadow_count), random_value());
         end else if (r < ins_w + del_w + 2) begin
            send_request(REQ_W'($urandom_range(REQ_UNKNOWN_LAST, REQ_UNKNOWN_FIRST)),
                         POS_W'($urandom_range(127)), $urandom);
         end else if (r < ins_w + del_w + 2 + clr_w) begin
            send_request(REQ_CLEAR, POS_W'($urandom_range(127)), $urandom);
         end else if (r % 2 == 0) begin
            send_request(REQ_GET, random_position(shadow_count), $urandom);
         end else begin
            // search for a stored element half of the time
            if (shadow_count > 0 && $urandom_range(1) != 0)
               val = shadow_cells[$urandom_range(shadow_count - 1)];
            else
               val = random_value();
            send_request(REQ_LOCATE, POS_W'($urandom_range(127)), val);
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.req_type = REQ_GET;
      req_if.position = '0;
      req_if.value    = '0;
      steady_flow     = 1'b0;
      shadow_count    = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_each_operation();
      test_full_list();
      test_random_traffic();

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses, %0d mismatches.",
               items_sent, results_checked, error_count);
      $display("Locate matches: %0d, inserts refused on a full list: %0d.",
               locate_hits, full_refusals);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
